FILE: rtl/core/iwd_pkg.sv
// Shared types, constants and the month offset table of the ISO week date pipeline.
package iwd_pkg;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_MAR = 4'd3;
	localparam logic [3:0] MON_DEC = 4'd12;

	// ceil(2^20 / 25): exact quotient for a 15-bit dividend
	localparam logic [15:0] RECIP_25 = 16'd41944;
	localparam int          RECIP_25_SHIFT = 20;
	// ceil(2^11 / 7): exact quotient for a dividend below 682
	localparam logic [8:0]  RECIP_7 = 9'd293;
	localparam int          RECIP_7_SHIFT = 11;

	localparam logic [5:0] WEEK_FIRST = 6'd1;
	localparam logic [5:0] WEEK_SHORT = 6'd52;
	localparam logic [5:0] WEEK_LONG  = 6'd53;

	// after stage 1: clamped date, leap-count year and its quotients
	typedef struct packed {
		logic [16:0] year;
		logic [3:0]  mon;
		logic [4:0]  day;
		logic        a_neg;
		logic [16:0] a;
		logic [14:0] q4;
		logic [10:0] q100;
	} iwd_s1_t;

	// after stage 2: leap flag, day of year and weekday seed sum
	typedef struct packed {
		logic [16:0]       year;
		logic              a_neg;
		logic              s;
		logic [1:0]        e;
		logic signed [9:0] f;
		logic [17:0]       sum_ab;
	} iwd_yr_t;

	// after stage 3: weekday of the leap-count year start
	typedef struct packed {
		logic [16:0]       year;
		logic              s;
		logic [1:0]        e;
		logic [2:0]        g;
		logic signed [9:0] f;
	} iwd_g_t;

	// after stage 4: weekday and Thursday-aligned day index
	typedef struct packed {
		logic [16:0]       year;
		logic              s;
		logic [2:0]        g;
		logic [2:0]        d;
		logic signed [9:0] n;
	} iwd_wd_t;

	// days before the first of the month, less one for Jan/Feb,
	// plus 58 for March onward (leap day added separately)
	function automatic logic signed [9:0] month_off(input logic [3:0] mon);
		logic signed [9:0] r;
		case (mon)
			4'd1:    r = -10'sd1;
			4'd2:    r = 10'sd30;
			4'd3:    r = 10'sd58;
			4'd4:    r = 10'sd89;
			4'd5:    r = 10'sd119;
			4'd6:    r = 10'sd150;
			4'd7:    r = 10'sd180;
			4'd8:    r = 10'sd211;
			4'd9:    r = 10'sd242;
			4'd10:   r = 10'sd272;
			4'd11:   r = 10'sd303;
			4'd12:   r = 10'sd333;
			default: r = -10'sd1;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/iwd_leap.sv
// Stages 1 and 2: month clamp, leap counts by 4/100/400, day of year.
module iwd_leap (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [16:0]       year,
	input  logic [3:0]        month,
	input  logic [4:0]        day,
	output logic              out_valid,
	input  logic              out_ready,
	output iwd_pkg::iwd_yr_t  out_data
);
	import iwd_pkg::*;

	logic    valid_s1, valid_s2;
	logic    rdy1, rdy2;
	iwd_s1_t data_s1, s1_c;
	iwd_yr_t data_s2, s2_c;

	logic [3:0]  mon_c;
	logic [30:0] prod_c;
	logic [15:0] q100x25_c;
	logic [10:0] q400_c;
	logic [15:0] b_c;
	logic        hi_c;

	assign rdy2     = !valid_s2 || out_ready;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		if (month < MON_JAN) begin
			mon_c = MON_JAN;
		end else if (month > MON_DEC) begin
			mon_c = MON_DEC;
		end else begin
			mon_c = month;
		end
		s1_c.year  = year;
		s1_c.mon   = mon_c;
		s1_c.day   = day;
		s1_c.a_neg = (mon_c < MON_MAR) && (year == 17'd0);
		s1_c.a     = (mon_c < MON_MAR) ? year - 17'd1 : year;
		s1_c.q4    = s1_c.a[16:2];
		prod_c     = {16'd0, s1_c.q4} * {15'd0, RECIP_25};
		s1_c.q100  = prod_c[RECIP_25_SHIFT +: 11];
	end

	always_comb begin
		q100x25_c = {5'd0, data_s1.q100} * 16'd25;
		q400_c    = {2'd0, data_s1.q100[10:2]};
		b_c       = {1'b0, data_s1.q4} - {5'd0, data_s1.q100} + {5'd0, q400_c};
		hi_c      = data_s1.mon >= MON_MAR;
		s2_c.year   = data_s1.year;
		s2_c.a_neg  = data_s1.a_neg;
		s2_c.s      = !data_s1.a_neg && (data_s1.a[1:0] == 2'd0) &&
		              (({1'b0, data_s1.q4} != q100x25_c) || (data_s1.q100[1:0] == 2'd0));
		s2_c.e      = hi_c ? {1'b0, s2_c.s} + 2'd1 : 2'd0;
		s2_c.f      = $signed({5'd0, data_s1.day}) + month_off(data_s1.mon) +
		              $signed({9'd0, s2_c.s & hi_c});
		s2_c.sum_ab = {1'b0, data_s1.a} + {2'd0, b_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) data_s1 <= s1_c;
		if (rdy2 && valid_s1) data_s2 <= s2_c;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

FILE: rtl/core/iwd_weekday.sv
// Stages 3 and 4: mod-7 reductions giving the year-start and date weekdays.
module iwd_weekday (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  iwd_pkg::iwd_yr_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output iwd_pkg::iwd_wd_t  out_data
);
	import iwd_pkg::*;

	logic    valid_s3, valid_s4;
	logic    rdy3, rdy4;
	iwd_g_t  data_s3, s3_c;
	iwd_wd_t data_s4, s4_c;

	logic signed [10:0] t_c;

	// 8 = 1 mod 7: sum octal digits, then fold once more
	function automatic logic [2:0] mod7_18(input logic [17:0] x);
		logic [5:0] p;
		logic [3:0] q;
		p = {3'd0, x[17:15]} + {3'd0, x[14:12]} + {3'd0, x[11:9]} +
		    {3'd0, x[8:6]} + {3'd0, x[5:3]} + {3'd0, x[2:0]};
		q = {1'b0, p[5:3]} + {1'b0, p[2:0]};
		return (q >= 4'd7) ? 3'(q - 4'd7) : q[2:0];
	endfunction

	function automatic logic [2:0] mod7_9(input logic [8:0] x);
		logic [4:0] p;
		logic [3:0] q;
		p = {2'd0, x[8:6]} + {2'd0, x[5:3]} + {2'd0, x[2:0]};
		q = {2'd0, p[4:3]} + {1'b0, p[2:0]};
		return (q >= 4'd7) ? 3'(q - 4'd7) : q[2:0];
	endfunction

	assign rdy4     = !valid_s4 || out_ready;
	assign rdy3     = !valid_s3 || rdy4;
	assign in_ready = rdy3;

	always_comb begin
		s3_c.year = in_data.year;
		s3_c.s    = in_data.s;
		s3_c.e    = in_data.e;
		s3_c.f    = in_data.f;
		// year -1 (date in Jan/Feb of year 0): -2 mod 7
		s3_c.g    = in_data.a_neg ? 3'd5 : mod7_18(in_data.sum_ab);
	end

	always_comb begin
		// bias by 7 keeps the sum positive before reduction
		t_c = $signed({data_s3.f[9], data_s3.f}) + $signed({8'd0, data_s3.g}) -
		      $signed({9'd0, data_s3.e}) + 11'sd7;
		s4_c.year = data_s3.year;
		s4_c.s    = data_s3.s;
		s4_c.g    = data_s3.g;
		s4_c.d    = mod7_9(t_c[8:0]);
		s4_c.n    = data_s3.f + 10'sd3 - $signed({7'd0, s4_c.d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy3) valid_s3 <= in_valid;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && in_valid) data_s3 <= s3_c;
		if (rdy4 && valid_s3) data_s4 <= s4_c;
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

FILE: rtl/core/iwd_week.sv
// Stage 5: week number with year-boundary correction, output register.
module iwd_week (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  iwd_pkg::iwd_wd_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [5:0]        iso_week,
	output logic [16:0]       iso_week_year,
	output logic [2:0]        iso_weekday
);
	import iwd_pkg::*;

	logic        valid_s5;
	logic        rdy5;
	logic [5:0]  week_s5, week_c;
	logic [16:0] wyear_s5, wyear_c;
	logic [2:0]  wday_s5;
	logic [17:0] prod_c;
	logic        prev_c, next_c;

	assign rdy5     = !valid_s5 || out_ready;
	assign in_ready = rdy5;

	always_comb begin
		prev_c = in_data.n < 10'sd0;
		next_c = in_data.n > (10'sd364 + $signed({9'd0, in_data.s}));
		prod_c = {9'd0, in_data.n[8:0]} * {9'd0, RECIP_7};
		if (prev_c) begin
			week_c  = ({1'b0, in_data.g} >= ({3'd0, in_data.s} + 4'd5)) ?
			          WEEK_SHORT : WEEK_LONG;
			wyear_c = in_data.year - 17'd1;
		end else if (next_c) begin
			week_c  = WEEK_FIRST;
			wyear_c = in_data.year + 17'd1;
		end else begin
			week_c  = prod_c[RECIP_7_SHIFT +: 6] + WEEK_FIRST;
			wyear_c = in_data.year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (rdy5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && in_valid) begin
			week_s5  <= week_c;
			wyear_s5 <= wyear_c;
			wday_s5  <= in_data.d + 3'd1;
		end
	end

	assign out_valid     = valid_s5;
	assign iso_week      = week_s5;
	assign iso_week_year = wyear_s5;
	assign iso_weekday   = wday_s5;

endmodule

FILE: rtl/core/iso_week_date_top.sv
// Top level of the ISO 8601 week date converter.
//
// Input channel: in_valid / in_ready with year, month, day. One beat is one
// Gregorian date. Month 0 is read as January, months above 12 as December;
// days are not range-checked and roll into the adjacent month.
// Output channel: out_valid / out_ready with iso_week, iso_week_year and
// iso_weekday (1 = Monday .. 7 = Sunday). Every input beat gives one output
// beat, in order.
// Pipeline: five register stages; the accept edge loads s1, and the beat then
// moves on through s2 to s5, where out_valid rises and the result can leave:
//   s1 month clamp, year/4 and year/100 (reciprocal multiply)
//   s2 leap flag, leap count, day of year
//   s3 year-start weekday (mod 7 by octal digit folding)
//   s4 weekday of the date, Thursday-aligned day index
//   s5 week number (multiply by reciprocal of 7) and year correction
// Throughput: one date per cycle while out_ready stays high.
// Stall: a stage holds its beat while the next is full and not taking; empty
// stages keep filling, so nothing is dropped or repeated. in_ready is low only
// when all five stages hold a beat and out_ready is low.
// Reset: arst_n clears the stage valid bits; data registers are not reset.
module iso_week_date_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [16:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  iso_week,
	output logic [16:0] iso_week_year,
	output logic [2:0]  iso_weekday
);
	import iwd_pkg::*;

	iwd_yr_t yr_data;
	iwd_wd_t wd_data;
	logic    yr_valid, yr_ready;
	logic    wd_valid, wd_ready;

	// stages 1-2: leap arithmetic and day of year
	iwd_leap u_leap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.year      (year),
		.month     (month),
		.day       (day),
		.out_valid (yr_valid),
		.out_ready (yr_ready),
		.out_data  (yr_data)
	);

	// stages 3-4: weekday reductions
	iwd_weekday u_weekday (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (yr_valid),
		.in_ready  (yr_ready),
		.in_data   (yr_data),
		.out_valid (wd_valid),
		.out_ready (wd_ready),
		.out_data  (wd_data)
	);

	// stage 5: week number and output register
	iwd_week u_week (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (wd_valid),
		.in_ready      (wd_ready),
		.in_data       (wd_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.iso_week      (iso_week),
		.iso_week_year (iso_week_year),
		.iso_weekday   (iso_weekday)
	);

	// an empty output stage means nothing upstream can be blocked
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iso_weekday != 3'd0))
		else $error("weekday out of range");

	a_week_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iso_week != 6'd0) && (iso_week <= WEEK_LONG))
		else $error("week number out of range");

	// a stalled result holds still until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(iso_week) &&
		$stable(iso_week_year) && $stable(iso_weekday))
		else $error("output beat changed while stalled");

endmodule

FILE: bench/iso_week_date_checker.sv
`timescale 1ns / 1ps
// Channel monitor for the ISO week date converter: predicts each week date and compares.
module iso_week_date_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [16:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  iso_week,
	input  logic [16:0] iso_week_year,
	input  logic [2:0]  iso_weekday,
	output int          fail_count,
	output int          dates_due,
	output int          results_seen
);

	typedef struct packed {
		logic [5:0]  week;
		logic [16:0] wyear;
		logic [2:0]  wday;
	} week_date_t;

	typedef struct {
		logic [16:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		week_date_t  wd;
	} dated_beat_t;

	dated_beat_t week_dates_due[$];

	// floor division, so year zero and the year before it count right
	function automatic longint div_floor(input longint x, input longint m);
		longint q;
		q = x / m;
		if ((x % m) != 0 && x < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint leap_years_upto(input longint y);
		return div_floor(y, 4) - div_floor(y, 100) + div_floor(y, 400);
	endfunction

	function automatic week_date_t week_date_of(input logic [16:0] y_in,
			input logic [3:0] m_in, input logic [4:0] d_in);
		longint y, m, dd, a, b, s, e, f, g, wd, n, wk, wy;
		week_date_t r;
		y  = y_in;
		m  = m_in;
		dd = d_in;
		if (m < 1)
			m = 1;
		if (m > 12)
			m = 12;
		if (m < 3) begin
			a = y - 1;
			b = leap_years_upto(a);
			s = b - leap_years_upto(a - 1);
			e = 0;
			f = dd - 1 + 31 * (m - 1);
		end else begin
			a = y;
			b = leap_years_upto(a);
			s = b - leap_years_upto(a - 1);
			e = s + 1;
			f = dd + (153 * (m - 3) + 2) / 5 + 58 + s;
		end
		g  = a + b - div_floor(a + b, 7) * 7;
		wd = (f + g - e) - div_floor(f + g - e, 7) * 7;
		n  = f + 3 - wd;
		if (n < 0) begin
			wk = (g - s >= 5) ? 52 : 53;
			wy = y - 1;
		end else if (n > 364 + s) begin
			wk = 1;
			wy = y + 1;
		end else begin
			wk = div_floor(n, 7) + 1;
			wy = y;
		end
		wd = wd + 1;
		r.week  = wk[5:0];
		r.wyear = wy[16:0];
		r.wday  = wd[2:0];
		return r;
	endfunction

	task automatic flag_field(input string what, input dated_beat_t b,
			input int want, input int got);
		fail_count = fail_count + 1;
		$display("%0t: %s mismatch for %0d-%0d-%0d: expected %0d, actual %0d",
			$time, what, b.y, b.m, b.d, want, got);
	endtask

	initial begin
		fail_count   = 0;
		dates_due    = 0;
		results_seen = 0;
	end

	always @(posedge clk) begin : watch
		dated_beat_t b;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				b.y  = year;
				b.m  = month;
				b.d  = day;
				b.wd = week_date_of(year, month, day);
				week_dates_due.push_back(b);
			end
			if (out_valid && out_ready) begin
				results_seen = results_seen + 1;
				if (week_dates_due.size() == 0) begin
					fail_count = fail_count + 1;
					$display("%0t: result with nothing expected: expected none, actual %0d-W%0d-%0d",
						$time, iso_week_year, iso_week, iso_weekday);
				end else begin
					b = week_dates_due.pop_front();
					if (iso_week !== b.wd.week)
						flag_field("week", b, b.wd.week, iso_week);
					if (iso_week_year !== b.wd.wyear)
						flag_field("week year", b, b.wd.wyear, iso_week_year);
					if (iso_weekday !== b.wd.wday)
						flag_field("weekday", b, b.wd.wday, iso_weekday);
				end
			end
			dates_due = week_dates_due.size();
		end
	end

endmodule

FILE: bench/iso_week_date_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the ISO week date converter: clock, reset, date stimulus and verdict.
module iso_week_date_top_tb;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [16:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  iso_week;
	logic [16:0] iso_week_year;
	logic [2:0]  iso_weekday;

	int fail_count;
	int dates_due;
	int results_seen;
	int dates_sent;
	int directed_dates;
	int burst_left;

	iso_week_date_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.iso_week      (iso_week),
		.iso_week_year (iso_week_year),
		.iso_weekday   (iso_weekday)
	);

	// monitor/predictor sits beside the block and only watches the pins
	iso_week_date_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.iso_week      (iso_week),
		.iso_week_year (iso_week_year),
		.iso_weekday   (iso_weekday),
		.fail_count    (fail_count),
		.dates_due     (dates_due),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop; a correct run needs well under a tenth of this
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver back-pressure: the stall mode is redrawn at random periodically, so
	// that stalls land on every pipeline fill level, with full-rate stretches too.
	initial begin : stall_pattern
		int mode;
		int cyc;
		mode = 0;
		cyc  = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cyc % 97 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_ready <= 1'b1;                          // no stall
				1: out_ready <= 1'($urandom_range(0, 1));      // coin flip
				2: out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
				default: out_ready <= ((cyc % 5) < 3);         // fixed 3-of-5 duty
			endcase
			cyc = cyc + 1;
		end
	end

	// Present one date beat; stays at the negedge after acceptance. Bursts of
	// random length alternate with random gaps; a gap of zero means back-to-back.
	task automatic send_date(input logic [16:0] y, input logic [3:0] m,
			input logic [4:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		in_valid <= 1'b1;
		year     <= y;
		month    <= m;
		day      <= d;
		// in_ready read in the active region of the edge, before any flop updates
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		burst_left = burst_left - 1;
		dates_sent = dates_sent + 1;
	endtask

	// Sender backs off until every outstanding beat has come out the far side.
	task automatic hold_until_drained;
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (dates_due != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int y;
		int m;
		int d;
		int pick;
		int mdays;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		year       = '0;
		month      = '0;
		day        = '0;
		dates_sent = 0;
		burst_left = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed dates ----
		send_date(17'd1, 4'd1, 5'd1);             // earliest nominal date
		send_date(17'd0, 4'd1, 5'd1);             // year zero: week year -1 wraps
		send_date(17'd0, 4'd2, 5'd29);            // year zero is a leap year
		send_date(17'd0, 4'd3, 5'd1);
		send_date(17'd0, 4'd0, 5'd0);             // every field at zero
		send_date(17'h1FFFF, 4'd12, 5'd31);       // top of year field: still in its own week year
		send_date(17'h1FFFF, 4'hF, 5'h1F);        // every field at all ones
		send_date(17'd99999, 4'd12, 5'd31);       // top of nominal range
		send_date(17'd2021, 4'd0, 5'd3);          // month zero read as January
		send_date(17'd2020, 4'd13, 5'd31);        // month above twelve read as December
		send_date(17'd2020, 4'd15, 5'd1);
		send_date(17'd2021, 4'd3, 5'd0);          // day zero: last day of February
		send_date(17'd2021, 4'd1, 5'd0);          // day zero in January
		send_date(17'd2023, 4'd2, 5'd31);         // day past month end rolls into March
		send_date(17'd2024, 4'd4, 5'd31);
		send_date(17'd2021, 4'd1, 5'd1);          // previous year has 53 weeks
		send_date(17'd2022, 4'd1, 5'd1);          // previous year has 52 weeks
		send_date(17'd2024, 4'd12, 5'd30);        // week 1 of the next year
		send_date(17'd2026, 4'd12, 5'd31);        // week 53 inside its own year
		send_date(17'd2000, 4'd2, 5'd29);         // 400-year leap
		send_date(17'd1900, 4'd3, 5'd1);          // century, not leap
		send_date(17'd2100, 4'd2, 5'd29);         // not leap, rolls into March
		send_date(17'd2023, 4'd6, 5'd15);
		directed_dates = dates_sent;

		// pipeline must drain completely at least once mid-run
		hold_until_drained();

		// ---- random dates ----
		for (int k = 0; k < 1850; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// well-formed calendar date
				y = (pick < 30) ? $urandom_range(1583, 2400) : $urandom_range(1, 99999);
				m = $urandom_range(1, 12);
				mdays = (m == 2) ?
					(((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28) :
					((m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31);
				d = $urandom_range(1, mdays);
			end else if (pick < 75) begin
				// around the turn of the year, where week and week year shift
				y = $urandom_range(1, 99999);
				if ($urandom_range(0, 1)) begin
					m = 12;
					d = $urandom_range(22, 31);
				end else begin
					m = 1;
					d = $urandom_range(1, 10);
				end
			end else if (pick < 90) begin
				// raw field values, out-of-range month and day included
				y = $urandom_range(0, 131071);
				m = $urandom_range(0, 15);
				d = $urandom_range(0, 31);
			end else begin
				// extremes of the year field
				y = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(131064, 131071);
				m = $urandom_range(0, 15);
				d = $urandom_range(0, 31);
			end
			send_date(y[16:0], m[3:0], d[4:0]);
			if (k % 450 == 449)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (20) @(negedge clk);

		$display("Covered %0d dates (%0d directed), %0d results checked against the predictor;",
			dates_sent, directed_dates, results_seen);
		$display("  incl. year zero, 17-bit year wrap, month 0 and 13..15, day 0 and day overflow.");
		if (fail_count == 0 && dates_due == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/iwd_pkg.sv
rtl/core/iwd_leap.sv
rtl/core/iwd_weekday.sv
rtl/core/iwd_week.sv
rtl/core/iso_week_date_top.sv
bench/iso_week_date_checker.sv
bench/iso_week_date_top_tb.sv
